>>> hw/rtl/ter_pkg.sv
// package for the triangle edge rasterizer
// holds field widths, default frame geometry, setup sequencer constants, opcodes and controller states
// no dependencies
package ter_pkg;

  // field widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned RC_W    = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned TOTAL_W = 32;

  // vertex differences carry one extra bit, edge values hold two products
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned EDGE_W = PROD_W + 2;

  // default frame geometry
  localparam int unsigned FRAME_WIDTH_DEF  = 256;
  localparam int unsigned FRAME_HEIGHT_DEF = 192;
  localparam int unsigned ROW_PITCH_DEF    = 256;

  // setup sequencer: eight products, one accumulate behind
  localparam int unsigned STEP_W    = 4;
  localparam logic [STEP_W-1:0] SETUP_LAST = STEP_W'(8);

  // opcodes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RDWAIT,
    ST_BBOX,
    ST_SETUP,
    ST_SWEEP,
    ST_DONE
  } ter_state_e;

endpackage

>>> hw/rtl/ter_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module ter_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/triangle_edge_rasterizer.sv
// triangle rasterizer: edge functions swept over the clipped bounding box
// read: states READ, RDWAIT and DONE; draw: BBOX, SETUP, a SWEEP over every pixel
// of the clipped box, then DONE (zero area or empty box: no SWEEP); DONE holds while a result is stalled
// one item in flight: the next item is taken only after DONE has loaded the result
// after reset a clearing pass zeroes the frame store, FRAME_HEIGHT*ROW_PITCH
// words (49152 at default size), before the first item is taken
module triangle_edge_rasterizer #(
  parameter int unsigned FRAME_WIDTH  = ter_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = ter_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned ROW_PITCH    = ter_pkg::ROW_PITCH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               opcode_i,
  input  logic signed [ter_pkg::COORD_W-1:0] vert0_x_i,
  input  logic signed [ter_pkg::COORD_W-1:0] vert0_y_i,
  input  logic signed [ter_pkg::COORD_W-1:0] vert1_x_i,
  input  logic signed [ter_pkg::COORD_W-1:0] vert1_y_i,
  input  logic signed [ter_pkg::COORD_W-1:0] vert2_x_i,
  input  logic signed [ter_pkg::COORD_W-1:0] vert2_y_i,
  input  logic [ter_pkg::COLOR_W-1:0]        fill_color_i,
  input  logic [ter_pkg::COLOR_W-1:0]        border_color_i,
  input  logic [ter_pkg::RC_W-1:0]           read_col_i,
  input  logic [ter_pkg::RC_W-1:0]           read_row_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ter_pkg::COUNT_W-1:0]        pixels_this_item_o,
  output logic [ter_pkg::TOTAL_W-1:0]        pixels_total_o,
  output logic [ter_pkg::COLOR_W-1:0]        read_color_o,
  output logic                               was_degenerate_o
);
  import ter_pkg::*;

  localparam int unsigned DEPTH = FRAME_HEIGHT * ROW_PITCH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LAW   = $clog2(DEPTH + FRAME_WIDTH);
  localparam int unsigned XW    = $clog2(FRAME_WIDTH);
  localparam int unsigned YW    = $clog2(FRAME_HEIGHT);

  localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(FRAME_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(FRAME_HEIGHT - 1);
  localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);
  localparam logic [LAW-1:0] DEPTH_L  = LAW'(DEPTH);
  localparam logic [LAW-1:0] PITCH_L  = LAW'(ROW_PITCH);

  // control
  ter_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [TOTAL_W-1:0] total_q, total_d;

  // latched item
  logic                      op_q;
  logic signed [COORD_W-1:0] vx_q [3];
  logic signed [COORD_W-1:0] vy_q [3];
  logic [COLOR_W-1:0]        fill_q, border_q;
  logic [RC_W-1:0]           rcol_q, rrow_q;

  // box and edge state
  logic [XW-1:0]            lx_q, hx_q, x_q;
  logic [YW-1:0]            ly_q, hy_q, y_q;
  logic                     empty_q;
  logic signed [DIFF_W-1:0] ddx_q [3];
  logic signed [DIFF_W-1:0] ddy_q [3];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [EDGE_W-1:0] area_q;
  logic signed [EDGE_W-1:0] e_q    [3];
  logic signed [EDGE_W-1:0] erow_q [3];
  logic [LAW-1:0]           rowbase_q;
  logic [COUNT_W-1:0]       cnt_q;
  logic                     rd_ok_q;
  logic [COLOR_W-1:0]       res_color_q;

  // output register
  logic [COUNT_W-1:0] pix_out_q;
  logic [TOTAL_W-1:0] tot_out_q;
  logic [COLOR_W-1:0] color_out_q;
  logic               degen_out_q;

  // memory port
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [COLOR_W-1:0] mem_rdata;

  // bounding box and clipping
  logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;

  always_comb begin
    min_x = vx_q[0];
    max_x = vx_q[0];
    min_y = vy_q[0];
    max_y = vy_q[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_q[i] < min_x) min_x = vx_q[i];
      if (vx_q[i] > max_x) max_x = vx_q[i];
      if (vy_q[i] < min_y) min_y = vy_q[i];
      if (vy_q[i] > max_y) max_y = vy_q[i];
    end
    lo_x = (min_x < 0) ? '0 : min_x;
    lo_y = (min_y < 0) ? '0 : min_y;
    hi_x = (max_x > X_MAX) ? X_MAX : max_x;
    hi_y = (max_y > Y_MAX) ? Y_MAX : max_y;
  end

  // setup operands: even steps (px-ax)*(by-ay), odd steps (py-ay)*(bx-ax)
  logic signed [DIFF_W-1:0] op_p, op_a, op_m, op_diff;
  logic signed [PROD_W-1:0] prod_d;
  logic [1:0]               op_sel;

  always_comb begin
    op_sel = step_q[2:1];
    case (op_sel)
      2'd0: begin
        // signed area is edge 2 evaluated at vertex 2
        op_p = step_q[0] ? {vy_q[2][COORD_W-1], vy_q[2]} : {vx_q[2][COORD_W-1], vx_q[2]};
        op_a = step_q[0] ? {vy_q[0][COORD_W-1], vy_q[0]} : {vx_q[0][COORD_W-1], vx_q[0]};
        op_m = step_q[0] ? ddy_q[2] : ddx_q[2];
      end
      2'd1: begin
        op_p = step_q[0] ? DIFF_W'(ly_q) : DIFF_W'(lx_q);
        op_a = step_q[0] ? {vy_q[1][COORD_W-1], vy_q[1]} : {vx_q[1][COORD_W-1], vx_q[1]};
        op_m = step_q[0] ? ddy_q[0] : ddx_q[0];
      end
      2'd2: begin
        op_p = step_q[0] ? DIFF_W'(ly_q) : DIFF_W'(lx_q);
        op_a = step_q[0] ? {vy_q[2][COORD_W-1], vy_q[2]} : {vx_q[2][COORD_W-1], vx_q[2]};
        op_m = step_q[0] ? ddy_q[1] : ddx_q[1];
      end
      default: begin
        op_p = step_q[0] ? DIFF_W'(ly_q) : DIFF_W'(lx_q);
        op_a = step_q[0] ? {vy_q[0][COORD_W-1], vy_q[0]} : {vx_q[0][COORD_W-1], vx_q[0]};
        op_m = step_q[0] ? ddy_q[2] : ddx_q[2];
      end
    endcase
    op_diff = op_p - op_a;
    prod_d  = op_diff * op_m;
  end

  // accumulate the product of the previous step
  logic [STEP_W-1:0]        acc_idx;
  logic [1:0]               acc_tgt;
  logic signed [EDGE_W-1:0] prod_ext, acc_cur, acc_new;

  always_comb begin
    acc_idx  = step_q - STEP_W'(1);
    acc_tgt  = acc_idx[2:1];
    prod_ext = {{(EDGE_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    case (acc_tgt)
      2'd0:    acc_cur = area_q;
      2'd1:    acc_cur = e_q[0];
      2'd2:    acc_cur = e_q[1];
      default: acc_cur = e_q[2];
    endcase
    acc_new = acc_idx[0] ? (acc_cur - prod_ext) : prod_ext;
  end

  // pixel test and store address
  logic           pos_side, neg_side, on_edge, covered;
  logic [LAW-1:0] sweep_addr;
  logic           in_store;
  logic           x_last, y_last;

  always_comb begin
    pos_side = 1'b1;
    neg_side = 1'b1;
    on_edge  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (e_q[i] < 0) pos_side = 1'b0;
      if (e_q[i] > 0) neg_side = 1'b0;
      if (e_q[i] == 0) on_edge = 1'b1;
    end
    covered    = pos_side || neg_side;
    sweep_addr = rowbase_q + LAW'(x_q);
    in_store   = sweep_addr < DEPTH_L;
    x_last     = (x_q == hx_q);
    y_last     = (y_q == hy_q);
  end

  // read address
  logic [LAW-1:0] rd_addr;
  logic           rd_ok;

  always_comb begin
    rd_addr = LAW'(rrow_q) * PITCH_L + LAW'(rcol_q);
    rd_ok   = ({24'd0, rcol_q} < 32'(FRAME_WIDTH)) && ({24'd0, rrow_q} < 32'(FRAME_HEIGHT))
              && (rd_addr < DEPTH_L);
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_raddr = rd_addr[AW-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SWEEP: begin
        mem_we    = covered && in_store;
        mem_waddr = sweep_addr[AW-1:0];
        mem_wdata = on_edge ? border_q : fill_q;
      end
      default: ;
    endcase
  end

  ter_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // controller next state
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    clr_d    = clr_q;
    out_load = 1'b0;
    total_d  = total_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) state_d = (opcode_i == OP_READ) ? ST_READ : ST_BBOX;
      end
      ST_READ: state_d = ST_RDWAIT;
      ST_RDWAIT: state_d = ST_DONE;
      ST_BBOX: state_d = ST_SETUP;
      ST_SETUP: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == SETUP_LAST) begin
          state_d = (area_q == 0 || empty_q) ? ST_DONE : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (covered) total_d = total_q + TOTAL_W'(1);
        if (x_last && y_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q        <= opcode_i;
      vx_q[0]     <= vert0_x_i;
      vy_q[0]     <= vert0_y_i;
      vx_q[1]     <= vert1_x_i;
      vy_q[1]     <= vert1_y_i;
      vx_q[2]     <= vert2_x_i;
      vy_q[2]     <= vert2_y_i;
      fill_q      <= fill_color_i;
      border_q    <= border_color_i;
      rcol_q      <= read_col_i;
      rrow_q      <= read_row_i;
      cnt_q       <= '0;
      res_color_q <= '0;
    end
    case (state_q)
      ST_BBOX: begin
        lx_q    <= lo_x[XW-1:0];
        hx_q    <= hi_x[XW-1:0];
        ly_q    <= lo_y[YW-1:0];
        hy_q    <= hi_y[YW-1:0];
        empty_q <= (hi_x < lo_x) || (hi_y < lo_y);
        // per edge (a,b): x step is by-ay, y step is -(bx-ax)
        ddx_q[0] <= {vy_q[2][COORD_W-1], vy_q[2]} - {vy_q[1][COORD_W-1], vy_q[1]};
        ddy_q[0] <= {vx_q[2][COORD_W-1], vx_q[2]} - {vx_q[1][COORD_W-1], vx_q[1]};
        ddx_q[1] <= {vy_q[0][COORD_W-1], vy_q[0]} - {vy_q[2][COORD_W-1], vy_q[2]};
        ddy_q[1] <= {vx_q[0][COORD_W-1], vx_q[0]} - {vx_q[2][COORD_W-1], vx_q[2]};
        ddx_q[2] <= {vy_q[1][COORD_W-1], vy_q[1]} - {vy_q[0][COORD_W-1], vy_q[0]};
        ddy_q[2] <= {vx_q[1][COORD_W-1], vx_q[1]} - {vx_q[0][COORD_W-1], vx_q[0]};
      end
      ST_SETUP: begin
        prod_q <= prod_d;
        if (step_q == '0) begin
          x_q       <= lx_q;
          y_q       <= ly_q;
          rowbase_q <= LAW'(ly_q) * PITCH_L;
        end else begin
          case (acc_tgt)
            2'd0: area_q <= acc_new;
            2'd1: begin
              e_q[0]    <= acc_new;
              erow_q[0] <= acc_new;
            end
            2'd2: begin
              e_q[1]    <= acc_new;
              erow_q[1] <= acc_new;
            end
            default: begin
              e_q[2]    <= acc_new;
              erow_q[2] <= acc_new;
            end
          endcase
        end
      end
      ST_READ: rd_ok_q <= rd_ok;
      ST_RDWAIT: res_color_q <= rd_ok_q ? mem_rdata : '0;
      ST_SWEEP: begin
        if (covered && cnt_q != '1) cnt_q <= cnt_q + COUNT_W'(1);
        // step along the row, or back to the box's left edge on the next row
        if (x_last) begin
          x_q       <= lx_q;
          y_q       <= y_q + YW'(1);
          rowbase_q <= rowbase_q + PITCH_L;
          for (int i = 0; i < 3; i++) begin
            e_q[i]    <= erow_q[i] - {{(EDGE_W - DIFF_W){ddy_q[i][DIFF_W-1]}}, ddy_q[i]};
            erow_q[i] <= erow_q[i] - {{(EDGE_W - DIFF_W){ddy_q[i][DIFF_W-1]}}, ddy_q[i]};
          end
        end else begin
          x_q <= x_q + XW'(1);
          for (int i = 0; i < 3; i++) begin
            e_q[i] <= e_q[i] + {{(EDGE_W - DIFF_W){ddx_q[i][DIFF_W-1]}}, ddx_q[i]};
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      pix_out_q   <= cnt_q;
      tot_out_q   <= total_q;
      color_out_q <= res_color_q;
      degen_out_q <= (op_q == OP_DRAW) && (area_q == 0);
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign pixels_this_item_o = pix_out_q;
  assign pixels_total_o     = tot_out_q;
  assign read_color_o       = color_out_q;
  assign was_degenerate_o   = degen_out_q;

endmodule

>>> hw/rtl/ter_checker.sv
// port-level checks for the triangle edge rasterizer, bound to the top level
// depends on ter_pkg and the triangle_edge_rasterizer ports only
module ter_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [ter_pkg::COUNT_W-1:0]        pixels_this_item_o,
  input logic [ter_pkg::TOTAL_W-1:0]        pixels_total_o,
  input logic [ter_pkg::COLOR_W-1:0]        read_color_o,
  input logic                               was_degenerate_o
);
  import ter_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixels_this_item_o)
      && $stable(pixels_total_o) && $stable(read_color_o) && $stable(was_degenerate_o))
    else $error("stalled result changed");

  // one item at a time: ready drops after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

  // a zero-area draw reports no pixels and no read colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_degenerate_o |-> pixels_this_item_o == '0 && read_color_o == '0)
    else $error("degenerate draw reported pixels or colour");

  // a result is either a draw count or a read colour, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixels_this_item_o == '0 || read_color_o == '0)
    else $error("result mixes draw count and read colour");

endmodule

bind triangle_edge_rasterizer ter_checker u_ter_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .pixels_this_item_o(pixels_this_item_o),
  .pixels_total_o    (pixels_total_o),
  .read_color_o      (read_color_o),
  .was_degenerate_o  (was_degenerate_o)
);
